[rtl/core/pcs_pkg.sv]
`default_nettype none

package pcs_pkg;

  // Data format
  localparam int DATA_W   = 32;
  localparam int FRAC_W   = 16;
  localparam int PERIOD_W = DATA_W - 1;
  localparam int CFG_IDX_W = 3;

  // A gain is "active" when gain * 10000 >= 1.0 (at least 0.0001)
  localparam int EPS_SCALE = 10000;
  localparam int GAIN_MIN_INT = (2**FRAC_W + EPS_SCALE - 1) / EPS_SCALE;

  typedef logic signed [DATA_W-1:0] word_t;

  localparam word_t GAIN_ACTIVE_MIN = DATA_W'(GAIN_MIN_INT);

  // Reset values of the configuration registers
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(2**FRAC_W);
  localparam word_t INTEG_UPPER_RESET = DATA_W'(5000 * 2**FRAC_W);
  localparam word_t INTEG_LOWER_RESET = -INTEG_UPPER_RESET;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_KEEP   = 2'd1,
    OP_LOAD   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETPOINT    = 3'd0,
    CFG_GAIN_P      = 3'd1,
    CFG_GAIN_I      = 3'd2,
    CFG_GAIN_D      = 3'd3,
    CFG_STEP_PERIOD = 3'd4,
    CFG_INTEG_UPPER = 3'd5,
    CFG_INTEG_LOWER = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    op_t   operation;
    word_t measured;
    word_t new_error;
  } in_req_t;

  typedef struct packed {
    word_t drive;
    word_t p_term;
    word_t i_term;
    word_t d_term;
    logic  active;
  } out_req_t;

  // Magnitude of a signed word (most negative value maps to 2^(W-1))
  function automatic logic [DATA_W-1:0] mag(input word_t x);
    return x[DATA_W-1] ? DATA_W'(-x) : DATA_W'(x);
  endfunction

  // Clamp a magnitude to the signed range for its sign, then apply the sign
  function automatic word_t apply_sign(input logic neg, input logic over,
                                       input logic [DATA_W-1:0] m);
    logic [DATA_W-1:0] lim;
    logic [DATA_W-1:0] mm;
    lim = {1'b0, {(DATA_W-1){1'b1}}} + DATA_W'(neg);
    mm  = (over || (m > lim)) ? lim : m;
    return neg ? word_t'(-mm) : word_t'(mm);
  endfunction

endpackage

`default_nettype wire

[rtl/core/pid_controller_step.sv]
`default_nettype none

// Channel   Ports                            Direction  Payload
// in        in_valid / in_stall / in_data    request    pcs_pkg::in_req_t
// out       out_valid / out_stall / out_data result     pcs_pkg::out_req_t
// cfg       cfg_we / cfg_index / cfg_wdata   write      one register per write
//
// Load and clear requests give no result.
// An update keeps in_stall high through four passes of the bit-serial
// multiplier (error*dt, P, I, D) and the load of the output register. The
// D pass starts once the divider for the derivative is done; that divider
// runs alongside the first two passes.
// Reset is synchronous; state and config registers come up at reset values.
// A finished result waits in the output register while out_stall is high;
// a new request is taken meanwhile, and its result waits for that slot.
module pid_controller_step (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire pcs_pkg::in_req_t                  in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output pcs_pkg::out_req_t                      out_data,
  input  wire logic                              cfg_we,
  input  wire logic [pcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pcs_pkg::DATA_W-1:0]        cfg_wdata
);

  localparam int W  = pcs_pkg::DATA_W;
  localparam int PW = pcs_pkg::PERIOD_W;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_MUL_DT   = 7'b0000010,
    ST_MUL_P    = 7'b0000100,
    ST_MUL_I    = 7'b0001000,
    ST_DIV_WAIT = 7'b0010000,
    ST_MUL_D    = 7'b0100000,
    ST_FINISH   = 7'b1000000
  } state_t;

  // Saturate a two-bit-extended sum to the word range
  function automatic pcs_pkg::word_t sat_word(input logic signed [W+1:0] x);
    if (x[W+1:W-1] == 3'b000 || x[W+1:W-1] == 3'b111) begin
      return x[W-1:0];
    end
    return x[W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  endfunction

  state_t state_r;

  // Configuration registers
  pcs_pkg::word_t    setpoint_r, gain_p_r, gain_i_r, gain_d_r;
  pcs_pkg::word_t    integ_upper_r, integ_lower_r;
  logic [PW-1:0]     step_period_r;

  // Controller state and term registers
  pcs_pkg::word_t    err_now_r, err_before_r, integral_r;
  pcs_pkg::word_t    p_r, i_r, d_r;

  pcs_pkg::out_req_t out_data_r;
  logic              out_valid_r;

  logic              in_accept;
  logic              is_update;
  logic              out_free;
  logic signed [W+1:0] err_diff_fresh;
  pcs_pkg::word_t    err_fresh;
  pcs_pkg::word_t    err_sel;
  logic signed [W:0] err_change;
  logic signed [W:0] integ_sum;
  logic signed [W:0] integ_clamped;
  logic signed [W+1:0] drive_sum;
  logic              all_small;

  logic              mul_start;
  pcs_pkg::word_t    mul_a, mul_b;
  logic              mul_done;
  pcs_pkg::word_t    mul_prod;
  logic              div_start;
  logic              div_busy;
  pcs_pkg::word_t    div_quo;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign is_update = (in_data.operation == pcs_pkg::OP_UPDATE) ||
                     (in_data.operation == pcs_pkg::OP_KEEP);
  assign out_free  = !out_valid_r || !out_stall;

  // Error selection and change since last update
  always_comb begin
    err_diff_fresh = {{2{setpoint_r[W-1]}}, setpoint_r} -
                     {{2{in_data.measured[W-1]}}, in_data.measured};
    err_fresh      = sat_word(err_diff_fresh);
    err_sel        = (in_data.operation == pcs_pkg::OP_UPDATE) ? err_fresh : err_now_r;
    err_change     = {err_sel[W-1], err_sel} - {err_before_r[W-1], err_before_r};
  end

  // Integral update with clamp; upper limit checked first
  always_comb begin
    integ_sum = {integral_r[W-1], integral_r} + {mul_prod[W-1], mul_prod};
    if (integ_sum > $signed({integ_upper_r[W-1], integ_upper_r})) begin
      integ_clamped = {integ_upper_r[W-1], integ_upper_r};
    end else if (integ_sum < $signed({integ_lower_r[W-1], integ_lower_r})) begin
      integ_clamped = {integ_lower_r[W-1], integ_lower_r};
    end else begin
      integ_clamped = integ_sum;
    end
  end

  // Output sum and gain activity
  always_comb begin
    drive_sum = {{2{p_r[W-1]}}, p_r} + {{2{i_r[W-1]}}, i_r} + {{2{d_r[W-1]}}, d_r};
    all_small = (gain_p_r < pcs_pkg::GAIN_ACTIVE_MIN) &&
                (gain_i_r < pcs_pkg::GAIN_ACTIVE_MIN) &&
                (gain_d_r < pcs_pkg::GAIN_ACTIVE_MIN);
  end

  // Multiplier operand selection per sequencer step
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept && is_update) begin
          mul_start = 1'b1;
          mul_a     = err_sel;
          mul_b     = $signed({1'b0, step_period_r});
          div_start = 1'b1;
        end
      end
      ST_MUL_DT: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = gain_p_r;
          mul_b     = err_now_r;
        end
      end
      ST_MUL_P: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = gain_i_r;
          mul_b     = integral_r;
        end
      end
      ST_DIV_WAIT: begin
        if (!div_busy) begin
          mul_start = 1'b1;
          mul_a     = gain_d_r;
          mul_b     = div_quo;
        end
      end
      ST_MUL_I, ST_MUL_D, ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r    <= '0;
      gain_p_r      <= '0;
      gain_i_r      <= '0;
      gain_d_r      <= '0;
      step_period_r <= pcs_pkg::PERIOD_RESET;
      integ_upper_r <= pcs_pkg::INTEG_UPPER_RESET;
      integ_lower_r <= pcs_pkg::INTEG_LOWER_RESET;
    end else if (cfg_we) begin
      unique case (pcs_pkg::cfg_idx_t'(cfg_index))
        pcs_pkg::CFG_SETPOINT:    setpoint_r    <= cfg_wdata;
        pcs_pkg::CFG_GAIN_P:      gain_p_r      <= cfg_wdata;
        pcs_pkg::CFG_GAIN_I:      gain_i_r      <= cfg_wdata;
        pcs_pkg::CFG_GAIN_D:      gain_d_r      <= cfg_wdata;
        pcs_pkg::CFG_STEP_PERIOD: step_period_r <= cfg_wdata[PW-1:0];
        pcs_pkg::CFG_INTEG_UPPER: integ_upper_r <= cfg_wdata;
        pcs_pkg::CFG_INTEG_LOWER: integ_lower_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Sequencer and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      err_now_r    <= '0;
      err_before_r <= '0;
      integral_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      // finish state owns the valid flag while it hands over a result
      if (out_valid_r && !out_stall && state_r != ST_FINISH) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            case (in_data.operation) inside
              pcs_pkg::OP_UPDATE, pcs_pkg::OP_KEEP: begin
                err_now_r    <= err_sel;
                err_before_r <= err_sel;
                state_r      <= ST_MUL_DT;
              end
              pcs_pkg::OP_LOAD: begin
                err_now_r <= in_data.new_error;
              end
              pcs_pkg::OP_CLEAR: begin
                err_now_r    <= '0;
                err_before_r <= '0;
                integral_r   <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_MUL_DT: begin
          if (mul_done) begin
            integral_r <= integ_clamped[W-1:0];
            state_r    <= ST_MUL_P;
          end
        end
        ST_MUL_P: begin
          if (mul_done) begin
            state_r <= ST_MUL_I;
          end
        end
        ST_MUL_I: begin
          if (mul_done) begin
            state_r <= ST_DIV_WAIT;
          end
        end
        ST_DIV_WAIT: begin
          if (!div_busy) begin
            state_r <= ST_MUL_D;
          end
        end
        ST_MUL_D: begin
          if (mul_done) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Term capture and output register
  always_ff @(posedge clk) begin
    if (mul_done && state_r == ST_MUL_P) begin
      p_r <= mul_prod;
    end
    if (mul_done && state_r == ST_MUL_I) begin
      i_r <= mul_prod;
    end
    if (mul_done && state_r == ST_MUL_D) begin
      d_r <= mul_prod;
    end
    if (state_r == ST_FINISH && out_free) begin
      out_data_r.drive  <= sat_word(drive_sum);
      out_data_r.p_term <= p_r;
      out_data_r.i_term <= i_r;
      out_data_r.d_term <= d_r;
      out_data_r.active <= !all_small;
    end
  end

  pcs_mul_serial u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  pcs_div_serial u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start),
    .num_i   (err_change),
    .den_i   (step_period_r),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[rtl/core/pcs_mul_serial.sv]
`default_nettype none

// Shift-add multiplier, one multiplier bit per cycle, on magnitudes.
// Result is the Q product truncated toward zero and saturated.
module pcs_mul_serial (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start_i,
  input  wire pcs_pkg::word_t a_i,
  input  wire pcs_pkg::word_t b_i,
  output logic                done_o,
  output pcs_pkg::word_t      prod_o
);

  localparam int W     = pcs_pkg::DATA_W;
  localparam int CNT_W = $clog2(W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [2*W-1:0]   acc_r;
  logic [2*W-1:0]   acc_nxt;
  logic [W-1:0]     mcand_r;
  logic             neg_r;
  logic [W:0]       part_sum;

  // One add of the multiplicand into the upper half, then shift right
  always_comb begin
    part_sum = acc_r[0] ? ({1'b0, acc_r[2*W-1:W]} + {1'b0, mcand_r})
                        : {1'b0, acc_r[2*W-1:W]};
    acc_nxt  = {part_sum, acc_r[W-1:1]};
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start_i) begin
      acc_r   <= {{W{1'b0}}, pcs_pkg::mag(a_i)};
      mcand_r <= pcs_pkg::mag(b_i);
      neg_r   <= a_i[W-1] ^ b_i[W-1];
    end else if (busy_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign done_o = done_r;
  assign prod_o = pcs_pkg::apply_sign(neg_r,
                                      |acc_r[2*W-1:W+pcs_pkg::FRAC_W],
                                      acc_r[W+pcs_pkg::FRAC_W-1:pcs_pkg::FRAC_W]);

endmodule

`default_nettype wire

[rtl/core/pcs_div_serial.sv]
`default_nettype none

// Restoring radix-2 divider: (|num| << FRAC_W) / den, one quotient bit per
// cycle, truncated toward zero and saturated. A zero period saturates to
// the sign of the numerator; a zero numerator gives zero.
module pcs_div_serial (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start_i,
  input  wire logic signed [pcs_pkg::DATA_W:0]  num_i,
  input  wire logic [pcs_pkg::PERIOD_W-1:0]     den_i,
  output logic                                  busy_o,
  output pcs_pkg::word_t                        quo_o
);

  localparam int W     = pcs_pkg::DATA_W;
  localparam int PW    = pcs_pkg::PERIOD_W;
  localparam int DIV_W = W + 1 + pcs_pkg::FRAC_W;
  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] dvd_r;
  logic [PW-1:0]    rem_r;
  logic [PW-1:0]    rem_nxt;
  logic [PW-1:0]    den_r;
  logic [W-1:0]     q_r;
  logic             ovf_r;
  logic             neg_r;
  logic             zero_r;
  logic [W:0]       num_mag;
  logic [PW:0]      trial;
  logic [PW:0]      trial_diff;
  logic             ge;

  assign num_mag = num_i[W] ? (W+1)'(-num_i) : (W+1)'(num_i);

  // Trial subtract of the divisor
  always_comb begin
    trial      = {rem_r, dvd_r[DIV_W-1]};
    trial_diff = trial - {1'b0, den_r};
    ge         = (trial >= {1'b0, den_r});
    rem_nxt    = ge ? trial_diff[PW-1:0] : trial[PW-1:0];
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start_i) begin
      dvd_r  <= {num_mag, {pcs_pkg::FRAC_W{1'b0}}};
      rem_r  <= '0;
      den_r  <= den_i;
      q_r    <= '0;
      ovf_r  <= 1'b0;
      neg_r  <= num_i[W];
      zero_r <= (num_mag == '0);
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DIV_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      q_r   <= {q_r[W-2:0], ge};
      ovf_r <= ovf_r | q_r[W-1];
    end
  end

  assign busy_o = busy_r;
  assign quo_o  = zero_r ? '0 : pcs_pkg::apply_sign(neg_r, ovf_r, q_r);

endmodule

`default_nettype wire

[rtl/core/pcs_checker.sv]
`default_nettype none

// Port-level checks for the PID step block
module pcs_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire pcs_pkg::in_req_t              in_data,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire pcs_pkg::out_req_t             out_data
);

  // Held result stays presented
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  // Load and clear requests never produce a result
  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid &&
    (in_data.operation == pcs_pkg::OP_LOAD || in_data.operation == pcs_pkg::OP_CLEAR)
    |=> !out_valid)
    else $error("result after load or clear");

  // An update occupies the block until its result is formed
  a_update_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall &&
    (in_data.operation == pcs_pkg::OP_UPDATE || in_data.operation == pcs_pkg::OP_KEEP)
    |=> in_stall)
    else $error("update request did not busy the block");

endmodule

bind pid_controller_step pcs_checker u_pcs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
